// ===== rtl/ttm_pkg.sv =====
package ttm_pkg;

	localparam int TIME_W   = 32;
	localparam int SUM_W    = 40;
	localparam int COUNT_W  = 16;
	localparam int TEMPO_W  = 14;
	localparam int DIGIT_W  = 4;
	localparam int BRIGHT_W = 4;
	localparam int CFG_IDX_W = 2;

	// The divider walks one dividend bit a cycle; both divisions use the full sum width.
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [SUM_W-1:0]   RATE_SCALE = SUM_W'(600000000);
	localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [TEMPO_W-1:0] TEMPO_CLIP = TEMPO_W'(9999);

	localparam logic [DIGIT_W-1:0] DIG_BLANK = DIGIT_W'(10);
	localparam logic [DIGIT_W-1:0] DIG_DASH  = DIGIT_W'(11);

	localparam logic [TIME_W-1:0]   TIMEOUT_RST  = TIME_W'(5000000);
	localparam logic [TIME_W-1:0]   DEBOUNCE_RST = TIME_W'(50000);
	localparam logic [BRIGHT_W-1:0] IDLE_BRIGHT_RST   = BRIGHT_W'(4);
	localparam logic [BRIGHT_W-1:0] ACTIVE_BRIGHT_RST = BRIGHT_W'(10);

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_BRIGHT   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BRIGHT = CFG_IDX_W'(3);

endpackage

// ===== rtl/tap_tempo_meter.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid, in_stall   | button_level, time_us
// output  | out       | out_valid, out_stall | tempo_tenths, tempo_valid, digit_*, brightness, redraw
// config  | in        | cfg_we               | cfg_index, cfg_data
//
// A beat runs from its accepting edge to the edge that loads its result through the timestamp
// checks, the rate divide and accumulate when a press follows an earlier one, the average setup
// and divide, clip and binary-to-decimal conversion once two beats are in, and the output load;
// both divides run on one shared divider. in_stall is high from the accepting edge until that
// load, and a held output beat keeps the sequencer waiting there; arst_n resets all state and
// registers to their idle values.
module tap_tempo_meter
	import ttm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 button_level,
	input  logic [TIME_W-1:0]    time_us,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TEMPO_W-1:0]   tempo_tenths,
	output logic                 tempo_valid,
	output logic [DIGIT_W-1:0]   digit_hundreds,
	output logic [DIGIT_W-1:0]   digit_tens,
	output logic [DIGIT_W-1:0]   digit_ones,
	output logic [DIGIT_W-1:0]   digit_tenths,
	output logic [BRIGHT_W-1:0]  brightness,
	output logic                 redraw
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TIMEOUT,
		S_DEBOUNCE,
		S_DIV_RATE,
		S_ACCUM,
		S_AVG,
		S_DIV_AVG,
		S_CLIP,
		S_BCD,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [TIME_W-1:0]   timeout_q;
	logic [TIME_W-1:0]   debounce_q;
	logic [BRIGHT_W-1:0] idle_bright_q;
	logic [BRIGHT_W-1:0] active_bright_q;

	// Tempo tracking state.
	logic                last_level_q;
	logic [TIME_W-1:0]   last_change_q;
	logic [TIME_W-1:0]   last_beat_q;
	logic [COUNT_W-1:0]  beat_count_q;
	logic [SUM_W-1:0]    rate_sum_q;
	logic [BRIGHT_W-1:0] cur_bright_q;

	// The sample being worked on.
	logic                level_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   interval_q;
	logic                press_q;

	// Shared divider: remainder, dividend/quotient shift register, divisor.
	logic [TIME_W-1:0]   rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [TIME_W-1:0]   dvs_q;
	logic [STEP_W-1:0]   step_q;

	// Binary-to-decimal conversion registers.
	logic [TEMPO_W-1:0]     bin_q;
	logic [4*DIGIT_W-1:0]   bcd_q;
	logic [TEMPO_W-1:0]     tempo_q;

	logic [TIME_W-1:0]   since_beat;
	logic [TIME_W-1:0]   since_change;
	logic [TIME_W:0]     trial;
	logic [TIME_W+1:0]   trial_diff;
	logic                trial_ge;
	logic [TIME_W-1:0]   rem_next;
	logic [SUM_W:0]      sum_wide;
	logic [4*DIGIT_W-1:0] bcd_adj;
	logic                out_free;

	assign since_beat   = now_q - last_beat_q;
	assign since_change = now_q - last_change_q;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	// The remainder stays below the divisor, so the trial value is below twice the divisor.
	assign trial      = {rem_q, quo_q[SUM_W-1]};
	assign trial_diff = {1'b0, trial} - {2'b00, dvs_q};
	assign trial_ge   = ~trial_diff[TIME_W+1];
	assign rem_next   = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];

	// Quotient of the rate divide is below 2^30, so the sum cannot wrap past one carry.
	assign sum_wide = {1'b0, rate_sum_q} + {1'b0, quo_q};

	// Double-dabble correction: each decimal digit of 5 or more gets 3 added before the shift.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign out_free = ~out_valid | ~out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q       <= TIMEOUT_RST;
			debounce_q      <= DEBOUNCE_RST;
			idle_bright_q   <= IDLE_BRIGHT_RST;
			active_bright_q <= ACTIVE_BRIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT:       timeout_q       <= cfg_data;
				REG_DEBOUNCE:      debounce_q      <= cfg_data;
				REG_IDLE_BRIGHT:   idle_bright_q   <= cfg_data[BRIGHT_W-1:0];
				REG_ACTIVE_BRIGHT: active_bright_q <= cfg_data[BRIGHT_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_level_q   <= 1'b1;
			last_change_q  <= '0;
			last_beat_q    <= '0;
			beat_count_q   <= '0;
			rate_sum_q     <= '0;
			cur_bright_q   <= IDLE_BRIGHT_RST;
			level_q        <= 1'b1;
			now_q          <= '0;
			interval_q     <= '0;
			press_q        <= 1'b0;
			rem_q          <= '0;
			quo_q          <= '0;
			dvs_q          <= '0;
			step_q         <= '0;
			bin_q          <= '0;
			bcd_q          <= '0;
			tempo_q        <= '0;
			out_valid      <= 1'b0;
			tempo_tenths   <= '0;
			tempo_valid    <= 1'b0;
			digit_hundreds <= DIG_BLANK;
			digit_tens     <= DIG_BLANK;
			digit_ones     <= DIG_DASH;
			digit_tenths   <= DIG_DASH;
			brightness     <= IDLE_BRIGHT_RST;
			redraw         <= 1'b0;
		end else begin
			// A beat taken while the next result is being loaded is replaced, not cleared.
			if (out_valid && !out_stall && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						level_q <= button_level;
						now_q   <= time_us;
						press_q <= 1'b0;
						state_q <= S_TIMEOUT;
					end
				end

				// The interval since the last beat serves both the timeout and the rate.
				S_TIMEOUT: begin
					interval_q <= since_beat;
					if (beat_count_q != '0 && since_beat > timeout_q) begin
						beat_count_q <= '0;
						cur_bright_q <= idle_bright_q;
					end
					state_q <= S_DEBOUNCE;
				end

				S_DEBOUNCE: begin
					state_q <= S_AVG;
					if (level_q != last_level_q && since_change >= debounce_q) begin
						last_change_q <= now_q;
						last_level_q  <= level_q;
						if (!level_q) begin
							press_q <= 1'b1;
							if (beat_count_q == '0) begin
								// First tap of a capture.
								rate_sum_q   <= '0;
								cur_bright_q <= active_bright_q;
								last_beat_q  <= now_q;
								beat_count_q <= COUNT_W'(1);
							end else begin
								rem_q   <= '0;
								quo_q   <= RATE_SCALE;
								dvs_q   <= (interval_q == '0) ? TIME_W'(1) : interval_q;
								step_q  <= '0;
								state_q <= S_DIV_RATE;
							end
						end
					end
				end

				S_DIV_RATE: begin
					rem_q  <= rem_next;
					quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_ACCUM;
					end
				end

				S_ACCUM: begin
					rate_sum_q  <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
					last_beat_q <= now_q;
					if (beat_count_q != COUNT_MAX) begin
						beat_count_q <= beat_count_q + COUNT_W'(1);
					end
					state_q <= S_AVG;
				end

				S_AVG: begin
					if (beat_count_q > COUNT_W'(1)) begin
						rem_q   <= '0;
						quo_q   <= rate_sum_q;
						dvs_q   <= TIME_W'(beat_count_q - COUNT_W'(1));
						step_q  <= '0;
						state_q <= S_DIV_AVG;
					end else begin
						tempo_q <= '0;
						state_q <= S_OUT;
					end
				end

				S_DIV_AVG: begin
					rem_q  <= rem_next;
					quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_CLIP;
					end
				end

				S_CLIP: begin
					if (quo_q > SUM_W'(TEMPO_CLIP)) begin
						tempo_q <= TEMPO_CLIP;
						bin_q   <= TEMPO_CLIP;
					end else begin
						tempo_q <= quo_q[TEMPO_W-1:0];
						bin_q   <= quo_q[TEMPO_W-1:0];
					end
					bcd_q   <= '0;
					step_q  <= '0;
					state_q <= S_BCD;
				end

				S_BCD: begin
					{bcd_q, bin_q} <= {bcd_adj[4*DIGIT_W-2:0], bin_q, 1'b0};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(TEMPO_W - 1)) begin
						state_q <= S_OUT;
					end
				end

				S_OUT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						brightness   <= cur_bright_q;
						redraw       <= press_q;
						tempo_tenths <= tempo_q;
						if (beat_count_q > COUNT_W'(1)) begin
							tempo_valid  <= 1'b1;
							digit_tenths <= bcd_q[0 +: DIGIT_W];
							digit_ones   <= bcd_q[DIGIT_W +: DIGIT_W];
							digit_tens   <= (bcd_q[4*DIGIT_W-1:2*DIGIT_W] == '0) ?
							                DIG_BLANK : bcd_q[2*DIGIT_W +: DIGIT_W];
							digit_hundreds <= (bcd_q[4*DIGIT_W-1:3*DIGIT_W] == '0) ?
							                  DIG_BLANK : bcd_q[3*DIGIT_W +: DIGIT_W];
						end else begin
							tempo_valid    <= 1'b0;
							digit_hundreds <= DIG_BLANK;
							digit_tens     <= DIG_BLANK;
							digit_ones     <= DIG_DASH;
							digit_tenths   <= DIG_DASH;
						end
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ttm_checker.sv =====
module ttm_checker
	import ttm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [TEMPO_W-1:0]   tempo_tenths,
	input  logic                 tempo_valid,
	input  logic [DIGIT_W-1:0]   digit_hundreds,
	input  logic [DIGIT_W-1:0]   digit_tens,
	input  logic [DIGIT_W-1:0]   digit_ones,
	input  logic [DIGIT_W-1:0]   digit_tenths
);

	// A result waiting on the far side stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// Only one beat is worked on at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat accepted while the first is in progress");

	// Without a tempo the display shows dashes and the value reads zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tempo_valid |->
			tempo_tenths == '0 && digit_ones == DIG_DASH && digit_tenths == DIG_DASH &&
			digit_hundreds == DIG_BLANK && digit_tens == DIG_BLANK)
		else $error("invalid tempo not shown as dashes");

	// A valid tempo is clipped and its low digits are real decimal digits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tempo_valid |->
			tempo_tenths <= TEMPO_CLIP && digit_ones <= DIGIT_W'(9) &&
			digit_tenths <= DIGIT_W'(9))
		else $error("valid tempo out of range or digits malformed");

endmodule

bind tap_tempo_meter ttm_checker u_ttm_checker (.*);
